// ===== hdl/gdrc_pkg.sv =====
// Shared types, register codes and constants of the GPIO debounce and relay controller.
`default_nettype none
package gdrc_pkg;

	// Pin and field sizes
	localparam int NUM_IO   = 3;
	localparam int IO_W     = 3;
	localparam int TGT_W    = 3;
	localparam int TIME_W   = 32;
	localparam int MS_W     = 16;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 16;
	localparam int MODE_W   = 2;

	// Configuration register indexes
	localparam logic [CFG_AW-1:0] REG_RELAY_INVERT  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_IO_INVERT     = 3'd1;
	localparam logic [CFG_AW-1:0] REG_IO_MODE       = 3'd2;
	localparam logic [CFG_AW-1:0] REG_SETTLE_MS     = 3'd3;
	localparam logic [CFG_AW-1:0] REG_RESET_HOLD_MS = 3'd4;

	// Pin mode codes; the two remaining codes leave the pin inert
	localparam logic [MODE_W-1:0] MODE_OUT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_IN  = 2'd1;

	// Command target that selects the relay
	localparam logic [TGT_W-1:0] TGT_RELAY = 3'd0;

	// Register values after reset
	localparam logic                    RST_RELAY_INVERT  = 1'b0;
	localparam logic [IO_W-1:0]         RST_IO_INVERT     = 3'd0;
	localparam logic [MODE_W*IO_W-1:0]  RST_IO_MODE       = 6'd21;
	localparam logic [MS_W-1:0]         RST_SETTLE_MS     = 16'd50;
	localparam logic [MS_W-1:0]         RST_RESET_HOLD_MS = 16'd5000;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic [IO_W-1:0]   io_raw;
		logic              boot_level;
		logic              cmd_valid;
		logic [TGT_W-1:0]  cmd_target;
		logic              cmd_level;
	} in_item_t;

	typedef struct packed {
		logic            relay_drive;
		logic [IO_W-1:0] io_drive;
		logic            relay_on;
		logic [IO_W-1:0] io_level;
		logic            publish;
		logic            cmd_ignored;
		logic            factory_reset;
	} out_item_t;

	// Per-pin control from the top level
	typedef struct packed {
		logic              step;
		logic [MODE_W-1:0] mode;
		logic              sample;
		logic              cmd_we;
		logic              cmd_level;
	} pin_ctrl_t;

	// Per-pin status back to the top level
	typedef struct packed {
		logic level;
		logic changed;
	} pin_stat_t;

endpackage
`default_nettype wire

// ===== hdl/gdrc_pin.sv =====
// One IO pin: commanded output level or debounced input level.
`default_nettype none
module gdrc_pin (
	input  wire                               clk,
	input  wire                               arst_n,
	input  gdrc_pkg::pin_ctrl_t               ctrl,
	input  wire [gdrc_pkg::TIME_W-1:0]        now_ms,
	input  wire [gdrc_pkg::MS_W-1:0]          settle_ms,
	output gdrc_pkg::pin_stat_t               stat
);
	import gdrc_pkg::*;

	logic              level_q;
	logic              last_q;
	logic [TIME_W-1:0] change_q;

	logic              is_in;
	logic              edge_seen;
	logic [TIME_W-1:0] change_eff;
	logic [TIME_W-1:0] elapsed;
	logic              settled;
	logic              take_input;
	logic              level_nxt;

	// Restart the settle timer on a new sample, then accept a settled level unless a command write sets it
	always_comb begin
		is_in      = (ctrl.mode == MODE_IN);
		edge_seen  = is_in && (ctrl.sample != last_q);
		change_eff = edge_seen ? now_ms : change_q;
		elapsed    = now_ms - change_eff;
		settled    = (elapsed >= {{(TIME_W-MS_W){1'b0}}, settle_ms});
		take_input = is_in && settled && (ctrl.sample != level_q);
		if (ctrl.cmd_we) begin
			level_nxt = ctrl.cmd_level;
		end else if (take_input) begin
			level_nxt = ctrl.sample;
		end else begin
			level_nxt = level_q;
		end
	end

	assign stat.level   = level_nxt;
	assign stat.changed = take_input;

	// Advance pin state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= 1'b0;
			last_q   <= 1'b0;
			change_q <= '0;
		end else if (ctrl.step) begin
			level_q <= level_nxt;
			if (edge_seen) begin
				last_q   <= ctrl.sample;
				change_q <= now_ms;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/gpio_debounce_relay_controller.sv =====
// Top level of the GPIO debounce and relay controller.
// Usage:
//   Each input item is one poll: a millisecond timestamp, raw IO and boot pin
//   levels and an optional command. Each item gives exactly one result item
//   with the relay and IO drive levels, logical states and event flags.
//   Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
// Path: an accepted item waits in the input register and its result in the
//   result register, where out_valid rises; a stall can hold either one.
// Throughput: one item per cycle unless out_ready stalls; the state update for
//   a poll is a 32-bit subtract and compare per pin and for the boot timer.
// Stall: when out_ready is low the result register holds, the input register
//   holds its item, and in_ready drops only once both are full.
// Reset: arst_n clears the pin, relay and boot state to low, loads the
//   register defaults (all pins input, 50 ms debounce, 5000 ms hold) and
//   empties both registers. No pins are sampled at reset.
`default_nettype none
module gpio_debounce_relay_controller (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  gdrc_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  wire                              out_ready,
	output gdrc_pkg::out_item_t              out_data,
	input  wire                              cfg_we,
	input  wire [gdrc_pkg::CFG_AW-1:0]       cfg_addr,
	input  wire [gdrc_pkg::CFG_DW-1:0]       cfg_wdata
);
	import gdrc_pkg::*;

	// Configuration registers
	logic                   relay_inv_q;
	logic [IO_W-1:0]        io_inv_q;
	logic [MODE_W*IO_W-1:0] io_mode_q;
	logic [MS_W-1:0]        debounce_q;
	logic [MS_W-1:0]        hold_q;

	// Controller state
	logic              relay_q;
	logic              boot_held_q;
	logic [TIME_W-1:0] press_q;

	// Pipeline registers
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_q;

	logic      adv;
	logic      step;

	pin_ctrl_t pin_ctrl [NUM_IO];
	pin_stat_t pin_stat [NUM_IO];

	logic            relay_nxt;
	logic            tgt_hit;
	logic            cmd_ignored;
	logic            any_change;
	logic            boot_pressed;
	logic [TIME_W-1:0] press_eff;
	logic [TIME_W-1:0] hold_elapsed;
	logic            freset;
	logic [IO_W-1:0] levels;
	logic [IO_W-1:0] drive;
	out_item_t       result;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_inv_q <= RST_RELAY_INVERT;
			io_inv_q    <= RST_IO_INVERT;
			io_mode_q   <= RST_IO_MODE;
			debounce_q  <= RST_SETTLE_MS;
			hold_q      <= RST_RESET_HOLD_MS;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_RELAY_INVERT:  relay_inv_q <= cfg_wdata[0];
				REG_IO_INVERT:     io_inv_q    <= cfg_wdata[IO_W-1:0];
				REG_IO_MODE:       io_mode_q   <= cfg_wdata[MODE_W*IO_W-1:0];
				REG_SETTLE_MS:     debounce_q  <= cfg_wdata;
				REG_RESET_HOLD_MS: hold_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake: the input register moves on whenever the result register frees
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign step     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the item payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Drive the pin units
	generate
		for (genvar i = 0; i < NUM_IO; i++) begin : g_pin
			always_comb begin
				pin_ctrl[i].step      = step;
				pin_ctrl[i].mode      = io_mode_q[MODE_W*i +: MODE_W];
				pin_ctrl[i].sample    = item_s1.io_raw[i] ^ io_inv_q[i];
				pin_ctrl[i].cmd_we    = item_s1.cmd_valid
					&& (item_s1.cmd_target == TGT_W'(i + 1))
					&& (io_mode_q[MODE_W*i +: MODE_W] == MODE_OUT);
				pin_ctrl[i].cmd_level = item_s1.cmd_level;
			end

			gdrc_pin u_pin (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (pin_ctrl[i]),
				.now_ms      (item_s1.now_ms),
				.settle_ms   (debounce_q),
				.stat        (pin_stat[i])
			);
		end
	endgenerate

	// Apply the command, gather pin results and time the boot button
	always_comb begin
		tgt_hit    = 1'b0;
		any_change = 1'b0;
		levels     = '0;
		drive      = '0;
		for (int i = 0; i < NUM_IO; i++) begin
			tgt_hit    = tgt_hit || pin_ctrl[i].cmd_we;
			any_change = any_change || pin_stat[i].changed;
			levels[i]  = pin_stat[i].level;
			if (io_mode_q[MODE_W*i +: MODE_W] == MODE_OUT) begin
				drive[i] = pin_stat[i].level ^ io_inv_q[i];
			end
		end

		if (item_s1.cmd_valid && (item_s1.cmd_target == TGT_RELAY)) begin
			relay_nxt = item_s1.cmd_level;
		end else begin
			relay_nxt = relay_q;
		end
		cmd_ignored = item_s1.cmd_valid && (item_s1.cmd_target != TGT_RELAY) && !tgt_hit;

		boot_pressed = !item_s1.boot_level;
		press_eff    = boot_held_q ? press_q : item_s1.now_ms;
		hold_elapsed = item_s1.now_ms - press_eff;
		freset       = boot_pressed
			&& (hold_elapsed >= {{(TIME_W-MS_W){1'b0}}, hold_q});

		result.relay_drive   = relay_nxt ^ relay_inv_q;
		result.io_drive      = drive;
		result.relay_on      = relay_nxt;
		result.io_level      = levels;
		result.publish       = item_s1.cmd_valid || any_change;
		result.cmd_ignored   = cmd_ignored;
		result.factory_reset = freset;
	end

	// Advance relay and boot state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q     <= 1'b0;
			boot_held_q <= 1'b0;
			press_q     <= '0;
		end else if (step) begin
			relay_q     <= relay_nxt;
			boot_held_q <= boot_pressed;
			if (boot_pressed && !boot_held_q) begin
				press_q <= item_s1.now_ms;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// An ignored command is still a command, so it always publishes
	a_ignored_publishes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_q.cmd_ignored || out_q.publish))
		else $error("cmd_ignored without publish");

	// Factory reset is only flagged while the button is still held
	a_freset_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.factory_reset) |-> boot_held_q)
		else $error("factory_reset with button released");

	// A stalled input register keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost its item under stall");

	// An empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("in_ready low with empty result register");

	// The logical relay state in a result matches the stored state
	a_relay_state: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (out_q.relay_on == relay_q))
		else $error("relay_on differs from relay state");

endmodule
`default_nettype wire
